[rtl/dtq_pkg.sv]
// package for the deadline timer queue
// holds item and result codes, default sizes and the controller/datapath structs
package dtq_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int JOB_ID_BITS_DEF = 8;
	localparam int TIME_BITS_DEF   = 32;

	localparam logic [2:0] K_SCHED_AT = 3'd0;
	localparam logic [2:0] K_SCHED_IN = 3'd1;
	localparam logic [2:0] K_CANCEL   = 3'd2;
	localparam logic [2:0] K_QUERY    = 3'd3;
	localparam logic [2:0] K_TICK     = 3'd4;

	localparam logic [2:0] RK_ADDED    = 3'd0;
	localparam logic [2:0] RK_MOVED    = 3'd1;
	localparam logic [2:0] RK_SAME     = 3'd2;
	localparam logic [2:0] RK_FULL     = 3'd3;
	localparam logic [2:0] RK_CANCEL   = 3'd4;
	localparam logic [2:0] RK_QUERY    = 3'd5;
	localparam logic [2:0] RK_DISPATCH = 3'd6;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic lookup;
		logic apply;
		logic scan_step;
		logic take_best;
		logic emit_pend;
		logic emit_last;
	} dtq_cmd_t;

	typedef struct packed {
		logic out_free;
		logic scan_done;
		logic best_v;
		logic pend_v;
	} dtq_sts_t;

endpackage

[rtl/dtq_ctrl.sv]
// controller state machine for the deadline timer queue
// depends on dtq_pkg; drives commands into dtq_datapath
module dtq_ctrl import dtq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] kind,
	output logic       in_stall,
	input  dtq_sts_t   sts,
	output dtq_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_EMIT,
		S_SCAN,
		S_DISP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == K_TICK) begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end else if (kind == K_SCHED_AT || kind == K_SCHED_IN ||
						kind == K_CANCEL || kind == K_QUERY) begin
						cmd.capture = 1'b1;
						state_d     = S_LOOKUP;
					end
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done)
					state_d = S_DISP;
			end
			S_DISP: begin
				if (sts.best_v) begin
					// hold the new job back until the previous one has gone out
					if (!sts.pend_v || sts.out_free) begin
						cmd.take_best = 1'b1;
						cmd.emit_pend = sts.pend_v;
						state_d       = S_SCAN;
					end
				end else if (!sts.pend_v) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_pend = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[rtl/dtq_datapath.sv]
// job table, time counter, scan unit and output register
// depends on dtq_pkg; sequenced by dtq_ctrl
module dtq_datapath import dtq_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dtq_cmd_t               cmd,
	output dtq_sts_t               sts,
	input  logic [2:0]             kind,
	input  logic [JOB_ID_BITS-1:0] job_id,
	input  logic [TIME_BITS-1:0]   time_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             result_kind,
	output logic [JOB_ID_BITS-1:0] job_id_out,
	output logic                   flag,
	output logic                   last
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic [CAPACITY-1:0]    ent_valid_q;
	logic [JOB_ID_BITS-1:0] ent_job_q [CAPACITY];
	logic [TIME_BITS-1:0]   ent_dl_q  [CAPACITY];
	logic [TIME_BITS-1:0]   time_q;

	logic [2:0]             kind_q;
	logic [JOB_ID_BITS-1:0] job_q;
	logic [TIME_BITS-1:0]   dl_q;

	logic [CAPACITY-1:0]    hit_vec_q;
	logic [CAPACITY-1:0]    free_vec_q;
	logic                   hit_q;
	logic                   full_q;
	logic                   lt_q;
	logic                   due_q;

	logic [IDX_W-1:0]       cnt_q;
	logic                   best_v_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [JOB_ID_BITS-1:0] best_job_q;
	logic [TIME_BITS-1:0]   best_dl_q;
	logic                   pend_v_q;
	logic [JOB_ID_BITS-1:0] pend_job_q;

	logic                   out_valid_q;
	logic [2:0]             rk_q;
	logic [JOB_ID_BITS-1:0] oid_q;
	logic                   flag_q;
	logic                   last_q;

	logic [TIME_BITS:0]     sum;
	logic [TIME_BITS-1:0]   sat_dl;
	logic [CAPACITY-1:0]    match;
	logic [CAPACITY-1:0]    lt_vec;
	logic [CAPACITY-1:0]    due_vec;
	logic [CAPACITY-1:0]    free_vec;
	logic [JOB_ID_BITS-1:0] s_job;
	logic [TIME_BITS-1:0]   s_dl;
	logic                   cand;
	logic                   out_free;
	logic                   is_sched;

	// saturating deadline for schedule-in
	assign sum    = {1'b0, time_q} + {1'b0, time_value};
	assign sat_dl = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

	always_comb begin
		free_vec = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			match[i]   = ent_valid_q[i] && (ent_job_q[i] == job_q);
			lt_vec[i]  = dl_q < ent_dl_q[i];
			due_vec[i] = time_q >= ent_dl_q[i];
			if (!ent_valid_q[i])
				free_vec = CAPACITY'(1) << i;
		end
	end

	// one entry per cycle of the dispatch scan
	assign s_job = ent_job_q[cnt_q];
	assign s_dl  = ent_dl_q[cnt_q];
	assign cand  = ent_valid_q[cnt_q] && (s_dl <= time_q) &&
		(!best_v_q || (s_dl < best_dl_q) || ((s_dl == best_dl_q) && (s_job < best_job_q)));

	assign out_free = !out_valid_q || !out_stall;
	assign is_sched = (kind_q == K_SCHED_AT) || (kind_q == K_SCHED_IN);

	assign sts.out_free  = out_free;
	assign sts.scan_done = (cnt_q == IDX_W'(CAPACITY - 1));
	assign sts.best_v    = best_v_q;
	assign sts.pend_v    = pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			time_q      <= '0;
			best_v_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.scan_start) begin
				if (time_q != '1)
					time_q <= time_q + TIME_BITS'(1);
				cnt_q    <= '0;
				best_v_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (cand)
					best_v_q <= 1'b1;
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (cmd.take_best) begin
				ent_valid_q[best_idx_q] <= 1'b0;
				pend_v_q                <= 1'b1;
				best_v_q                <= 1'b0;
				cnt_q                   <= '0;
			end else if (cmd.emit_pend) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.apply) begin
				if (is_sched && !hit_q && !full_q)
					ent_valid_q <= ent_valid_q | free_vec_q;
				else if (kind_q == K_CANCEL)
					ent_valid_q <= ent_valid_q & ~hit_vec_q;
			end
			if (cmd.apply || cmd.emit_pend)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			job_q  <= job_id;
			dl_q   <= (kind == K_SCHED_IN) ? sat_dl : time_value;
		end
		if (cmd.lookup) begin
			hit_vec_q  <= match;
			hit_q      <= |match;
			free_vec_q <= free_vec;
			full_q     <= &ent_valid_q;
			lt_q       <= |(match & lt_vec);
			due_q      <= |(match & due_vec);
		end
		if (cmd.scan_step && cand) begin
			best_idx_q <= cnt_q;
			best_job_q <= s_job;
			best_dl_q  <= s_dl;
		end
		if (cmd.take_best)
			pend_job_q <= best_job_q;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.apply && is_sched) begin
				if (hit_q && lt_q && hit_vec_q[i])
					ent_dl_q[i] <= dl_q;
				else if (!hit_q && !full_q && free_vec_q[i]) begin
					ent_dl_q[i]  <= dl_q;
					ent_job_q[i] <= job_q;
				end
			end
		end
		if (cmd.apply) begin
			oid_q  <= job_q;
			last_q <= 1'b1;
			flag_q <= 1'b0;
			case (kind_q)
				K_SCHED_AT, K_SCHED_IN: begin
					if (hit_q)
						rk_q <= lt_q ? RK_MOVED : RK_SAME;
					else
						rk_q <= full_q ? RK_FULL : RK_ADDED;
				end
				K_CANCEL: begin
					rk_q   <= RK_CANCEL;
					flag_q <= hit_q;
				end
				default: begin
					rk_q   <= RK_QUERY;
					flag_q <= hit_q && due_q;
				end
			endcase
		end else if (cmd.emit_pend) begin
			rk_q   <= RK_DISPATCH;
			oid_q  <= pend_job_q;
			flag_q <= 1'b0;
			last_q <= cmd.emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = rk_q;
	assign job_id_out  = oid_q;
	assign flag        = flag_q;
	assign last        = last_q;

endmodule

[rtl/deadline_timer_queue_core.sv]
// Deadline timer queue: a table of pending jobs, one deadline per job id,
// with a tick counter that dispatches due jobs earliest first, ties by lower id.
// Input channel (in_valid/in_stall): kind, job_id, time_value; a transfer
// happens when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall): result_kind, job_id_out, flag, last; last marks the
// final result of an item. A tick with nothing due and an unknown kind give
// no result.
// Schedule, cancel and query go through capture, parallel table lookup,
// then the result is loaded into the output register.
// A tick scans the table one entry per cycle to find the earliest due job:
// one scan per dispatched job plus a final empty one.
// in_stall is high while an item is in progress. A held result sits in the
// output register under out_stall; the block carries on up to the next
// result and then waits for the transfer, so nothing is lost.
// Reset clears all table entries, the time counter and both handshakes.
module deadline_timer_queue_core import dtq_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             kind,
	input  logic [JOB_ID_BITS-1:0] job_id,
	input  logic [TIME_BITS-1:0]   time_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             result_kind,
	output logic [JOB_ID_BITS-1:0] job_id_out,
	output logic                   flag,
	output logic                   last
);

	dtq_cmd_t cmd;
	dtq_sts_t sts;

	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtq_datapath #(
		.CAPACITY    (CAPACITY),
		.JOB_ID_BITS (JOB_ID_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.job_id      (job_id),
		.time_value  (time_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.job_id_out  (job_id_out),
		.flag        (flag),
		.last        (last)
	);

endmodule
